// ----- rtl/peak_preserving_decimator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Peak-preserving decimator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PEAK_PRESERVING_DECIMATOR_CORE_DEFINES_SVH
`define PEAK_PRESERVING_DECIMATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on clk_i, off while rst_ni is low.
`define PPDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PPDEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define PPDEC_ASSERT(lbl, prop, msg)
`define PPDEC_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/ppdec_pkg.sv -----
// ----------------------------------------------------------------------------
// Peak-preserving decimator package
// Shared types, constants and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppdec_pkg;

  localparam int PPDEC_MAX_CHANNELS = 1024;

  localparam int CH_W     = 10;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 12;
  localparam int COUNT_W  = 11;
  localparam int CFG_W    = 12;

  // Register reset values
  localparam logic               HIGHPASS_RST   = 1'b1;
  localparam logic [COUNT_W-1:0] AP_COUNT_RST   = 11'd384;
  localparam logic [COUNT_W-1:0] NEURAL_CNT_RST = 11'd768;
  localparam logic [POS_W-1:0]   DOWNSAMPLE_RST = 12'd1;

  typedef enum logic [1:0] {
    REG_HIGHPASS_ONLY = 2'd0,
    REG_AP_COUNT      = 2'd1,
    REG_NEURAL_COUNT  = 2'd2,
    REG_DOWNSAMPLE    = 2'd3
  } ppdec_reg_e;

  typedef enum logic [1:0] {
    KIND_SPIKE = 2'd0,
    KIND_LFP   = 2'd1,
    KIND_SYNC  = 2'd2
  } ppdec_kind_e;

  // Per-channel state word held in the state RAM
  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
  } ppdec_entry_t;

  // Magnitude of a signed 16-bit value, 17 bits so that -32768 fits
  function automatic logic [SAMPLE_W:0] ppdec_mag(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W:0] ext;
    ext = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ppdec_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read-first: a same-address write is not seen until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/peak_preserving_decimator_core.sv -----
// ----------------------------------------------------------------------------
// Peak-preserving decimator core
// Per-channel min/max peak decimation and pick decimation of interleaved samples.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, set by the single state RAM read/write per item,
// unless the output stalls; each result passes the update stage and the output register.
// Reset: config registers load defaults; a clearing pass then zeroes the state
// RAM, during which no input item is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "peak_preserving_decimator_core_defines.svh"

module peak_preserving_decimator_core
  import ppdec_pkg::*;
#(
  parameter int MAX_CHANNELS = PPDEC_MAX_CHANNELS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  // input items
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [47:0]        s_axis_tdata,  // channel, sample, partner_sample, zero pad
  input  wire logic               s_axis_tlast,  // chunk_end
  // result items
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [31:0]        m_axis_tdata,  // out_channel, point, zero pad
  output logic      [1:0]         m_axis_tuser   // kind
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CHANNELS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               highpass_q;
  logic [COUNT_W-1:0] ap_count_q;
  logic [COUNT_W-1:0] neural_q;
  logic [POS_W-1:0]   downsample_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highpass_q   <= HIGHPASS_RST;
      ap_count_q   <= AP_COUNT_RST;
      neural_q     <= NEURAL_CNT_RST;
      downsample_q <= DOWNSAMPLE_RST;
    end else if (cfg_valid_i) begin
      case (ppdec_reg_e'(cfg_index_i))
        REG_HIGHPASS_ONLY: highpass_q   <= cfg_data_i[0];
        REG_AP_COUNT:      ap_count_q   <= cfg_data_i[COUNT_W-1:0];
        REG_NEURAL_COUNT:  neural_q     <= cfg_data_i[COUNT_W-1:0];
        REG_DOWNSAMPLE:    downsample_q <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass
  // --------------------------------------------------------------------------
  logic          clear_q, clear_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clear_d    = clear_q;
    clr_addr_d = clr_addr_q;
    if (clear_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clear_d    = 1'b0;
        clr_addr_d = '0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clear_q    <= clear_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input decode (accept stage)
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]     in_channel;
  logic [SAMPLE_W-1:0] in_sample;
  logic [SAMPLE_W-1:0] in_partner;
  logic                in_accept;
  logic                in_ok;
  logic                in_spike;
  logic                pair_mode;
  logic [SAMPLE_W-1:0] in_value;
  ppdec_kind_e         in_kind;

  assign in_channel = s_axis_tdata[9:0];
  assign in_sample  = s_axis_tdata[25:10];
  assign in_partner = s_axis_tdata[41:26];

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_ok     = (32'(in_channel) < 32'(MAX_CHANNELS));
  assign in_spike  = ({1'b0, in_channel} < ap_count_q);
  assign pair_mode = !highpass_q && ({1'b0, neural_q} == {ap_count_q, 1'b0});
  // wraps to 16 bits
  assign in_value  = (in_spike && pair_mode) ? (in_sample + in_partner) : in_sample;

  always_comb begin
    if (in_spike) begin
      in_kind = KIND_SPIKE;
    end else if ({1'b0, in_channel} < neural_q) begin
      in_kind = KIND_LFP;
    end else begin
      in_kind = KIND_SYNC;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic                s1_ok_q;
  logic                s1_spike_q;
  logic                s1_last_q;
  logic [CH_W-1:0]     s1_channel_q;
  logic [AW-1:0]       s1_addr_q;
  logic [SAMPLE_W-1:0] s1_value_q;
  ppdec_kind_e         s1_kind_q;

  logic                fwd_valid_q;
  logic [AW-1:0]       fwd_addr_q;
  ppdec_entry_t        fwd_entry_q;

  ppdec_entry_t        ram_rdata;
  ppdec_entry_t        cur;
  ppdec_entry_t        upd;
  logic [SAMPLE_W-1:0] lo, hi, lo2, hi2;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    ds;
  logic                pos_zero;
  logic                close;
  logic                s1_emit;
  logic [SAMPLE_W-1:0] s1_point;
  logic                s1_fire;
  logic                s1_write;

  logic                out_valid_q;
  logic [CH_W-1:0]     out_channel_q;
  logic [SAMPLE_W-1:0] out_point_q;
  ppdec_kind_e         out_kind_q;

  // the item ahead wrote this entry at the edge our read was taken
  assign cur = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_entry_q : ram_rdata;

  always_comb begin
    ds       = (downsample_q == '0) ? POS_W'(1) : downsample_q;
    pos_zero = (cur.pos == '0);
    lo       = pos_zero ? s1_value_q : cur.low;
    hi       = pos_zero ? s1_value_q : cur.high;
    lo2      = ($signed(s1_value_q) < $signed(lo)) ? s1_value_q : lo;
    hi2      = ($signed(s1_value_q) > $signed(hi)) ? s1_value_q : hi;
    pos_inc  = {1'b0, cur.pos} + (POS_W+1)'(1);
    close    = (pos_inc >= {1'b0, ds}) || s1_last_q;
    upd.pos  = close ? '0 : pos_inc[POS_W-1:0];
    if (s1_spike_q && (ds > POS_W'(1))) begin
      upd.low  = lo2;
      upd.high = hi2;
      s1_emit  = s1_ok_q && close;
      s1_point = (ppdec_mag(lo2) > ppdec_mag(hi2)) ? lo2 : hi2;
    end else begin
      upd.low  = lo;
      upd.high = hi;
      s1_emit  = s1_ok_q && pos_zero;
      s1_point = s1_value_q;
    end
  end

  assign s1_fire  = s1_valid_q && (!s1_emit || !out_valid_q || m_axis_tready);
  assign s1_write = s1_fire && s1_ok_q;

  assign s_axis_tready = !clear_q && (!s1_valid_q || s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ok_q      <= in_ok;
      s1_spike_q   <= in_spike;
      s1_last_q    <= s_axis_tlast;
      s1_channel_q <= in_channel;
      s1_addr_q    <= AW'(in_channel);
      s1_value_q   <= in_value;
      s1_kind_q    <= in_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_write) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      fwd_addr_q  <= s1_addr_q;
      fwd_entry_q <= upd;
    end
  end

  // --------------------------------------------------------------------------
  // State RAM
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  ppdec_entry_t  ram_wdata;

  assign ram_we    = clear_q || s1_write;
  assign ram_waddr = clear_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clear_q ? ppdec_entry_t'('0) : upd;

  ppdec_ram #(
    .WIDTH ($bits(ppdec_entry_t)),
    .DEPTH (MAX_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (AW'(in_channel)),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      out_channel_q <= s1_channel_q;
      out_point_q   <= s1_point;
      out_kind_q    <= s1_kind_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_point_q, out_channel_q};
  assign m_axis_tuser  = out_kind_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PPDEC_ASSERT_IMP(a_no_accept_in_clear, clear_q, !s_axis_tready,
                    "item taken during clearing pass")
  `PPDEC_ASSERT_IMP(a_no_item_write_in_clear, s1_valid_q, !clear_q,
                    "update stage busy during clearing pass")
  `PPDEC_ASSERT_IMP(a_accept_needs_free_stage, in_accept && s1_valid_q, s1_fire,
                    "item taken while update stage is blocked")
  `PPDEC_ASSERT(a_clear_ends_wrapped, $fell(clear_q) |-> (clr_addr_q == '0),
                "clearing pass ended with counter not wrapped")

endmodule

`default_nettype wire
